/* design/nmea_rmc_pkg.sv */
package nmea_rmc_pkg;

  // Default sizes
  localparam int LINE_LIMIT_DEF = 299;
  localparam int LAT_KEEP_DEF   = 9;
  localparam int LON_KEEP_DEF   = 11;
  localparam int FLAG_KEEP_DEF  = 4;

  // Fixed widths
  localparam int LEN_W  = 4;  // token char count and lat/lon kept length
  localparam int FLEN_W = 3;  // flag kept length
  localparam int TOK_W  = 3;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_VOID   = 8'h56;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Token indexes
  localparam logic [TOK_W-1:0] TOK_NAME   = 3'd0;
  localparam logic [TOK_W-1:0] TOK_STATUS = 3'd2;
  localparam logic [TOK_W-1:0] TOK_LAT    = 3'd3;
  localparam logic [TOK_W-1:0] TOK_NS     = 3'd4;
  localparam logic [TOK_W-1:0] TOK_LON    = 3'd5;
  localparam logic [TOK_W-1:0] TOK_EW     = 3'd6;
  localparam logic [TOK_W-1:0] TOK_ALL    = 3'd7;

  localparam logic [LEN_W-1:0] NAME_LEN = 4'd6;
  localparam logic [LEN_W-1:0] CHARS_MAX = 4'd15;
  localparam logic [LEN_W-1:0] LAT_SKIP = 4'd4;
  localparam logic [LEN_W-1:0] LON_SKIP = 4'd5;

  // Output part codes
  localparam logic [1:0] PART_NS  = 2'd0;
  localparam logic [1:0] PART_LAT = 2'd1;
  localparam logic [1:0] PART_EW  = 2'd2;
  localparam logic [1:0] PART_LON = 2'd3;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CHECK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic take;        // input item accepted this cycle
    logic load_count;  // sentence accepted: load count, reset cursor
    logic drain_en;    // walk stored texts into the output register
  } cmd_t;

  typedef struct packed {
    logic term;        // current byte terminates an open sentence
    logic accept_ok;   // finished sentence qualifies
    logic drain_done;  // nothing left to emit
  } sts_t;

  function automatic logic [7:0] rmc_name_char(input logic [LEN_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h24;  // $
      4'd1:    ch = 8'h47;  // G
      4'd2:    ch = 8'h4E;  // N
      4'd3:    ch = 8'h52;  // R
      4'd4:    ch = 8'h4D;  // M
      4'd5:    ch = 8'h43;  // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* design/nmea_rmc_ctrl.sv */
module nmea_rmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nmea_rmc_pkg::sts_t  sts,
  output nmea_rmc_pkg::cmd_t  cmd
);

  nmea_rmc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nmea_rmc_pkg::ST_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nmea_rmc_pkg::ST_RECV: begin
        if (in_valid && sts.term) state_nxt = nmea_rmc_pkg::ST_CHECK;
      end
      nmea_rmc_pkg::ST_CHECK: begin
        state_nxt = sts.accept_ok ? nmea_rmc_pkg::ST_DRAIN : nmea_rmc_pkg::ST_RECV;
      end
      nmea_rmc_pkg::ST_DRAIN: begin
        if (sts.drain_done) state_nxt = nmea_rmc_pkg::ST_RECV;
      end
      default: state_nxt = nmea_rmc_pkg::ST_RECV;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd.take       = 1'b0;
    cmd.load_count = 1'b0;
    cmd.drain_en   = 1'b0;
    case (state_r)
      nmea_rmc_pkg::ST_RECV: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      nmea_rmc_pkg::ST_CHECK: begin
        cmd.load_count = sts.accept_ok;
      end
      nmea_rmc_pkg::ST_DRAIN: begin
        cmd.drain_en = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

/* design/nmea_rmc_dp.sv */
module nmea_rmc_dp #(
  parameter int LINE_LIMIT = nmea_rmc_pkg::LINE_LIMIT_DEF,
  parameter int LAT_KEEP   = nmea_rmc_pkg::LAT_KEEP_DEF,
  parameter int LON_KEEP   = nmea_rmc_pkg::LON_KEEP_DEF,
  parameter int FLAG_KEEP  = nmea_rmc_pkg::FLAG_KEEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_rx_byte,
  input  nmea_rmc_pkg::cmd_t cmd,
  output nmea_rmc_pkg::sts_t sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic [1:0]         out_part,
  output logic               out_last
);

  localparam int LEN_W  = nmea_rmc_pkg::LEN_W;
  localparam int FLEN_W = nmea_rmc_pkg::FLEN_W;
  localparam int TOK_W  = nmea_rmc_pkg::TOK_W;
  localparam int KW     = $clog2(LINE_LIMIT + 1);
  localparam int LATW   = (LAT_KEEP > 1) ? $clog2(LAT_KEEP) : 1;
  localparam int LONW   = (LON_KEEP > 1) ? $clog2(LON_KEEP) : 1;
  localparam int FW     = (FLAG_KEEP > 1) ? $clog2(FLAG_KEEP) : 1;
  localparam int TOTAL  = 2 * FLAG_KEEP + LAT_KEEP + LON_KEEP;
  localparam int CW     = $clog2(TOTAL + 1);

  localparam logic [KW-1:0]    LIMIT_K  = KW'(LINE_LIMIT);
  localparam logic [LEN_W-1:0] LAT_K    = LEN_W'(LAT_KEEP);
  localparam logic [LEN_W-1:0] LON_K    = LEN_W'(LON_KEEP);
  localparam logic [LEN_W-1:0] FLAG_K   = LEN_W'(FLAG_KEEP);

  // Sentence and token tracking
  logic              in_sentence_r, in_sentence_nxt;
  logic [KW-1:0]     kept_r, kept_nxt;
  logic [TOK_W-1:0]  tok_r, tok_nxt;
  logic              inside_r, inside_nxt;
  logic [LEN_W-1:0]  chars_r, chars_nxt;
  logic              name_ok_r, name_ok_nxt;
  logic              void_r, void_nxt;
  logic [LEN_W-1:0]  lat_len_r, lat_len_nxt;
  logic [LEN_W-1:0]  lon_len_r, lon_len_nxt;
  logic [FLEN_W-1:0] ns_len_r, ns_len_nxt;
  logic [FLEN_W-1:0] ew_len_r, ew_len_nxt;

  // Stored texts
  logic [7:0] lat_q [LAT_KEEP];
  logic [7:0] lon_q [LON_KEEP];
  logic [7:0] ns_q  [FLAG_KEEP];
  logic [7:0] ew_q  [FLAG_KEEP];

  logic             lat_we, lon_we, ns_we, ew_we;
  logic [LEN_W-1:0] wr_idx;

  // Drain cursor and output register
  logic [1:0]       part_r, part_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       oc_r;
  logic [1:0]       op_r, op_nxt;
  logic             ol_r, ol_nxt;

  logic [7:0] b;
  logic is_dollar, is_term, is_comma;
  logic start, tb_en;
  logic [TOK_W-1:0] tok_b;
  logic inside_b, name_b, void_b;
  logic [LEN_W-1:0] chars_b, c_cur;

  logic [LEN_W-1:0] len_sel;
  logic             pos_ok, slot_free, emit;
  logic [CW-1:0]    total;

  assign b         = in_rx_byte;
  assign is_dollar = (b == nmea_rmc_pkg::CH_DOLLAR);
  assign is_term   = (b == nmea_rmc_pkg::CH_LF) || (b == nmea_rmc_pkg::CH_STAR);
  assign is_comma  = (b == nmea_rmc_pkg::CH_COMMA);

  assign sts.term       = in_sentence_r && !is_dollar && is_term;
  assign sts.accept_ok  = !void_r && name_ok_r && (tok_r == nmea_rmc_pkg::TOK_ALL);
  assign sts.drain_done = (rem_r == '0);

  assign start = cmd.take && !in_sentence_r && is_dollar;
  assign tb_en = start || (cmd.take && in_sentence_r && !is_dollar && !is_term &&
                           (kept_r < LIMIT_K) && (b != nmea_rmc_pkg::CH_NUL));

  // Per-sentence context, cleared on '$'
  assign tok_b    = start ? '0 : tok_r;
  assign inside_b = start ? 1'b0 : inside_r;
  assign chars_b  = start ? '0 : chars_r;
  assign name_b   = start ? 1'b1 : name_ok_r;
  assign void_b   = start ? 1'b0 : void_r;
  assign c_cur    = inside_b ? chars_b : '0;
  assign wr_idx   = c_cur;

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    kept_nxt        = kept_r;
    tok_nxt         = tok_b;
    inside_nxt      = inside_b;
    chars_nxt       = chars_b;
    name_ok_nxt     = name_b;
    void_nxt        = void_b;
    lat_len_nxt     = start ? '0 : lat_len_r;
    lon_len_nxt     = start ? '0 : lon_len_r;
    ns_len_nxt      = start ? '0 : ns_len_r;
    ew_len_nxt      = start ? '0 : ew_len_r;
    lat_we          = 1'b0;
    lon_we          = 1'b0;
    ns_we           = 1'b0;
    ew_we           = 1'b0;

    if (start) begin
      in_sentence_nxt = 1'b1;
      kept_nxt        = KW'(1);
    end else if (cmd.take && sts.term) begin
      in_sentence_nxt = 1'b0;
      kept_nxt        = '0;
    end else if (cmd.take && in_sentence_r && !is_dollar && (kept_r < LIMIT_K)) begin
      // a zero byte closes the usable text
      kept_nxt = (b == nmea_rmc_pkg::CH_NUL) ? LIMIT_K : kept_r + KW'(1);
    end

    // token end on comma or terminator
    if ((tb_en && is_comma && inside_b) || (cmd.take && sts.term && inside_r)) begin
      if (tok_b == nmea_rmc_pkg::TOK_NAME && chars_b != nmea_rmc_pkg::NAME_LEN)
        name_ok_nxt = 1'b0;
      if (tok_b != nmea_rmc_pkg::TOK_ALL) tok_nxt = tok_b + TOK_W'(1);
      inside_nxt = 1'b0;
    end else if (tb_en && !is_comma) begin
      inside_nxt = 1'b1;
      case (tok_b)
        nmea_rmc_pkg::TOK_NAME: begin
          if (c_cur >= nmea_rmc_pkg::NAME_LEN || b != nmea_rmc_pkg::rmc_name_char(c_cur))
            name_ok_nxt = 1'b0;
        end
        nmea_rmc_pkg::TOK_STATUS: begin
          if (c_cur == '0 && b == nmea_rmc_pkg::CH_VOID) void_nxt = 1'b1;
        end
        nmea_rmc_pkg::TOK_LAT: begin
          if (c_cur < LAT_K) begin
            lat_we      = 1'b1;
            lat_len_nxt = c_cur + LEN_W'(1);
          end
        end
        nmea_rmc_pkg::TOK_NS: begin
          if (c_cur < FLAG_K) begin
            ns_we      = 1'b1;
            ns_len_nxt = FLEN_W'(c_cur + LEN_W'(1));
          end
        end
        nmea_rmc_pkg::TOK_LON: begin
          if (c_cur < LON_K) begin
            lon_we      = 1'b1;
            lon_len_nxt = c_cur + LEN_W'(1);
          end
        end
        nmea_rmc_pkg::TOK_EW: begin
          if (c_cur < FLAG_K) begin
            ew_we      = 1'b1;
            ew_len_nxt = FLEN_W'(c_cur + LEN_W'(1));
          end
        end
        default: ;
      endcase
      chars_nxt = (c_cur < nmea_rmc_pkg::CHARS_MAX) ? c_cur + LEN_W'(1) : c_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) lat_q[wr_idx[LATW-1:0]] <= b;
    if (lon_we) lon_q[wr_idx[LONW-1:0]] <= b;
    if (ns_we)  ns_q[wr_idx[FW-1:0]]    <= b;
    if (ew_we)  ew_q[wr_idx[FW-1:0]]    <= b;
  end

  // Emitted count: all kept chars minus one skipped char in lat and lon
  always_comb begin
    total = CW'(ns_len_r) + CW'(lat_len_r) + CW'(ew_len_r) + CW'(lon_len_r);
    if (lat_len_r > nmea_rmc_pkg::LAT_SKIP) total = total - CW'(1);
    if (lon_len_r > nmea_rmc_pkg::LON_SKIP) total = total - CW'(1);
  end

  always_comb begin
    case (part_r)
      nmea_rmc_pkg::PART_NS:  len_sel = LEN_W'(ns_len_r);
      nmea_rmc_pkg::PART_LAT: len_sel = lat_len_r;
      nmea_rmc_pkg::PART_EW:  len_sel = LEN_W'(ew_len_r);
      default:                len_sel = lon_len_r;
    endcase
  end

  assign pos_ok = (j_r < len_sel) &&
                  !(part_r == nmea_rmc_pkg::PART_LAT && j_r == nmea_rmc_pkg::LAT_SKIP) &&
                  !(part_r == nmea_rmc_pkg::PART_LON && j_r == nmea_rmc_pkg::LON_SKIP);
  assign slot_free = !ov_r || !out_stall;
  assign emit      = cmd.drain_en && slot_free && pos_ok && (rem_r != '0);

  always_comb begin
    part_nxt = part_r;
    j_nxt    = j_r;
    rem_nxt  = rem_r;
    ov_nxt   = ov_r && out_stall;
    op_nxt   = op_r;
    ol_nxt   = ol_r;
    if (cmd.load_count) begin
      part_nxt = nmea_rmc_pkg::PART_NS;
      j_nxt    = '0;
      rem_nxt  = total;
    end else if (cmd.drain_en && slot_free && rem_r != '0) begin
      // skipped or past-end positions just advance the cursor
      if ({1'b0, j_r} + (LEN_W + 1)'(1) < {1'b0, len_sel}) begin
        j_nxt = j_r + LEN_W'(1);
      end else begin
        j_nxt    = '0;
        part_nxt = part_r + 2'd1;
      end
      if (emit) begin
        ov_nxt  = 1'b1;
        op_nxt  = part_r;
        ol_nxt  = (rem_r == CW'(1));
        rem_nxt = rem_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      kept_r        <= '0;
      tok_r         <= '0;
      inside_r      <= 1'b0;
      chars_r       <= '0;
      name_ok_r     <= 1'b0;
      void_r        <= 1'b0;
      lat_len_r     <= '0;
      lon_len_r     <= '0;
      ns_len_r      <= '0;
      ew_len_r      <= '0;
      part_r        <= '0;
      j_r           <= '0;
      rem_r         <= '0;
      ov_r          <= 1'b0;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      kept_r        <= kept_nxt;
      tok_r         <= tok_nxt;
      inside_r      <= inside_nxt;
      chars_r       <= chars_nxt;
      name_ok_r     <= name_ok_nxt;
      void_r        <= void_nxt;
      lat_len_r     <= lat_len_nxt;
      lon_len_r     <= lon_len_nxt;
      ns_len_r      <= ns_len_nxt;
      ew_len_r      <= ew_len_nxt;
      part_r        <= part_nxt;
      j_r           <= j_nxt;
      rem_r         <= rem_nxt;
      ov_r          <= ov_nxt;
    end
  end

  // stored texts are read straight into the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      case (part_r)
        nmea_rmc_pkg::PART_NS:  oc_r <= ns_q[j_r[FW-1:0]];
        nmea_rmc_pkg::PART_LAT: oc_r <= lat_q[j_r[LATW-1:0]];
        nmea_rmc_pkg::PART_EW:  oc_r <= ew_q[j_r[FW-1:0]];
        default:                oc_r <= lon_q[j_r[LONW-1:0]];
      endcase
    end
    op_r <= op_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_part  = op_r;
  assign out_last  = ol_r;

endmodule

/* design/nmea_rmc_position_parser.sv */
// NMEA RMC position parser: takes one received byte per item and, for each
// $GNRMC sentence with a non-void status and all position fields present,
// emits the N/S flag, latitude, E/W flag and longitude text one character
// per item (latitude drops its char at index 4, longitude at index 5; out_last
// marks the final character). Ordinary bytes are accepted one per cycle.
// A terminator ('*' or newline) stalls input while the sentence is qualified
// in the check state; if it qualifies, input stays stalled while the
// stored-text cursor walks one position per cycle whenever the output
// register is free, at most 2*FLAG_KEEP + LAT_KEEP + LON_KEEP positions;
// out_stall on a full output register holds the cursor.
module nmea_rmc_position_parser #(
  parameter int LINE_LIMIT = nmea_rmc_pkg::LINE_LIMIT_DEF,
  parameter int LAT_KEEP   = nmea_rmc_pkg::LAT_KEEP_DEF,
  parameter int LON_KEEP   = nmea_rmc_pkg::LON_KEEP_DEF,
  parameter int FLAG_KEEP  = nmea_rmc_pkg::FLAG_KEEP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic [1:0] out_part,
  output logic       out_last
);

  nmea_rmc_pkg::cmd_t cmd;
  nmea_rmc_pkg::sts_t sts;

  nmea_rmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nmea_rmc_dp #(
    .LINE_LIMIT (LINE_LIMIT),
    .LAT_KEEP   (LAT_KEEP),
    .LON_KEEP   (LON_KEEP),
    .FLAG_KEEP  (FLAG_KEEP)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_part   (out_part),
    .out_last   (out_last)
  );

endmodule
